@@ hdl/sorted_set_table_unit_assert.svh @@
// Assertion macros for the sorted set table.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SORTED_SET_TABLE_UNIT_ASSERT_SVH
`define SORTED_SET_TABLE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication.
`define SST_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sorted set table: same-cycle check failed");

// Next-cycle implication.
`define SST_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sorted set table: next-cycle check failed");

`else

`define SST_ASSERT_IMPLY(label, ante, cons)
`define SST_ASSERT_NEXT(label, ante, cons)

`endif

`endif

@@ hdl/sst_pkg.sv @@
`timescale 1ns / 1ps

package sst_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2
  } op_t;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DELETED   = 3'd3,
    ST_ABSENT    = 3'd4,
    ST_READ      = 3'd5
  } status_t;

  // Broadcast controls from the sequencer to every cell.
  typedef struct packed {
    logic sample;  // latch compare flags and read tap
    logic look;    // item reads or deletes at a position
    logic ins;     // commit an insert
    logic del;     // commit a delete
  } cell_ctl_t;

  // Fan-in of one OR-tree node.
  localparam int FANIN = 8;

  // Number of nodes at tree level l (level 0 is the leaves).
  function automatic int level_size(int n, int l);
    int s;
    s = n;
    for (int m = 0; m < l; m++) begin
      s = (s + FANIN - 1) / FANIN;
    end
    return s;
  endfunction

  // Offset of level l in the flat node array (level 1 starts at 0).
  function automatic int level_offset(int n, int l);
    int ofs;
    ofs = 0;
    for (int m = 1; m < l; m++) begin
      ofs = ofs + level_size(n, m);
    end
    return ofs;
  endfunction

  // Registered levels needed to reduce n leaves to one node.
  function automatic int tree_levels(int n);
    int s;
    int lv;
    s  = n;
    lv = 0;
    while (s > 1) begin
      s  = (s + FANIN - 1) / FANIN;
      lv = lv + 1;
    end
    return lv;
  endfunction

endpackage

@@ hdl/sst_in_if.sv @@
`timescale 1ns / 1ps

interface sst_in_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  opcode;
  logic signed [31:0] value;
  logic        [5:0]  position;

  modport source (output valid, output opcode, output value, output position, input ready);
  modport sink   (input valid, input opcode, input value, input position, output ready);
endinterface

@@ hdl/sst_out_if.sv @@
`timescale 1ns / 1ps

interface sst_out_if;
  logic               valid;
  logic               ready;
  logic        [2:0]  status;
  logic signed [31:0] read_value;
  logic        [6:0]  entry_count;

  modport source (output valid, output status, output read_value, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input read_value, input entry_count,
                  output ready);
endinterface

@@ hdl/sst_cell.sv @@
`timescale 1ns / 1ps

module sst_cell #(
  parameter int VB  = 32,
  parameter int PW  = 7,
  parameter int IDX = 0
) (
  input  logic                     clk,
  input  sst_pkg::cell_ctl_t       ctl_i,
  input  logic signed [VB-1:0]     value_i,
  input  logic        [PW-1:0]     count_i,
  input  logic        [PW-1:0]     pos_i,
  input  logic signed [VB-1:0]     prev_entry_i,
  input  logic                     prev_gt_i,
  input  logic signed [VB-1:0]     next_entry_i,
  output logic signed [VB-1:0]     entry_o,
  output logic                     gt_o,
  output logic        [0:0]        eq_o,
  output logic        [VB-1:0]     tap_o
);

  localparam logic [PW-1:0] IDX_C = PW'(IDX);

  logic signed [VB-1:0] entry_r;
  logic                 gt_r;
  logic                 above_r;
  logic                 eq_r;
  logic                 shift_r;
  logic        [VB-1:0] tap_r;
  logic                 active;

  assign active = IDX_C < count_i;

  always_ff @(posedge clk) begin
    if (ctl_i.sample) begin
      gt_r    <= active && (entry_r > value_i);
      above_r <= !active || (entry_r > value_i);
      eq_r    <= active && (entry_r == value_i);
      shift_r <= IDX_C >= pos_i;
      tap_r   <= (active && ctl_i.look && (IDX_C == pos_i)) ? entry_r : '0;
    end
    // Insert: take the lower neighbor if it moves up, else take the new value
    // at the slot. Delete: pull the upper neighbor down.
    if (ctl_i.ins) begin
      if (prev_gt_i) begin
        entry_r <= prev_entry_i;
      end else if (above_r) begin
        entry_r <= value_i;
      end
    end else if (ctl_i.del && shift_r) begin
      entry_r <= next_entry_i;
    end
  end

  assign entry_o = entry_r;
  assign gt_o    = gt_r;
  assign eq_o    = eq_r;
  assign tap_o   = tap_r;

endmodule

@@ hdl/sst_or_tree.sv @@
`timescale 1ns / 1ps

module sst_or_tree #(
  parameter int WIDTH  = 1,
  parameter int LEAVES = 2
) (
  input  logic             clk,
  input  logic [WIDTH-1:0] leaf_i [LEAVES],
  output logic [WIDTH-1:0] root_o
);

  localparam int LV    = sst_pkg::tree_levels(LEAVES);
  localparam int TOTAL = sst_pkg::level_offset(LEAVES, LV + 1);

  logic [WIDTH-1:0] node_r [TOTAL];

  for (genvar l = 1; l <= LV; l++) begin : g_lvl
    localparam int NPREV = sst_pkg::level_size(LEAVES, l - 1);
    localparam int NCUR  = sst_pkg::level_size(LEAVES, l);
    localparam int OFS   = sst_pkg::level_offset(LEAVES, l);
    localparam int POFS  = sst_pkg::level_offset(LEAVES, l - 1);
    for (genvar j = 0; j < NCUR; j++) begin : g_node
      logic [WIDTH-1:0] grp [sst_pkg::FANIN];
      logic [WIDTH-1:0] acc;
      for (genvar k = 0; k < sst_pkg::FANIN; k++) begin : g_in
        if (j * sst_pkg::FANIN + k >= NPREV) begin : g_pad
          assign grp[k] = '0;
        end else if (l == 1) begin : g_leaf
          assign grp[k] = leaf_i[j * sst_pkg::FANIN + k];
        end else begin : g_inner
          assign grp[k] = node_r[POFS + j * sst_pkg::FANIN + k];
        end
      end
      always_comb begin
        acc = '0;
        for (int k = 0; k < sst_pkg::FANIN; k++) begin
          acc = acc | grp[k];
        end
      end
      always_ff @(posedge clk) begin
        node_r[OFS + j] <= acc;
      end
    end
  end

  assign root_o = node_r[TOTAL-1];

endmodule

@@ hdl/sorted_set_table_unit.sv @@
`timescale 1ns / 1ps
// Channel   Dir  Payload                                  Handshake
// in_item   in   opcode[1:0] value[31:0] position[5:0]    valid/ready
// out_item  out  status[2:0] read_value[31:0] count[6:0]  valid/ready
//
// Sequencing: an item is held from acceptance until its commit; the next item
//   is accepted only after that. LV = ceil(log8(CAPACITY)) is the depth of the
//   registered OR trees that gather the duplicate flag and the read tap.
// Reset: rst_n clears the entry count and the handshake state; cell contents
//   stay undefined until written and need no clearing pass.
// Stalls: a result waits in the output register; the next item is accepted
//   meanwhile, and its commit waits until the output register is free.

`include "sorted_set_table_unit_assert.svh"

module sorted_set_table_unit #(
  parameter int CAPACITY   = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic             clk,
  input  logic             rst_n,
  sst_in_if.sink           in_item,
  sst_out_if.source        out_item
);

  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int PW  = (CW > 6) ? CW : 6;
  localparam int LV  = sst_pkg::tree_levels(CAPACITY);
  localparam int LCW = $clog2(LV + 1);
  localparam int VB  = VALUE_BITS;

  localparam logic [CW-1:0]  CAP_C = CW'(CAPACITY);
  localparam logic [LCW-1:0] LV_C  = LCW'(LV);

  typedef enum logic {
    S_IDLE,
    S_SUM
  } state_t;

  // Sequencer state
  state_t                state_r;
  logic [LCW-1:0]        cnt_r;
  logic [CW-1:0]         count_r;
  logic [CW-1:0]         count_nxt;

  // Held item
  sst_pkg::op_t          op_r;
  logic [PW-1:0]         pos_r;
  logic signed [VB-1:0]  value_r;

  // Output register
  logic                  out_valid_r;
  logic [2:0]            status_r;
  logic [2:0]            status_nxt;
  logic [31:0]           read_value_r;
  logic [6:0]            entry_count_r;

  logic                  fire_in;
  logic                  commit;
  logic                  dup;
  logic                  full;
  logic                  pos_ok;
  logic [VB+31:0]        in_wide;
  logic signed [VB-1:0]  in_val;
  logic signed [VB-1:0]  bcast_value;
  logic [PW-1:0]         count_ext;
  logic [PW-1:0]         in_pos_ext;
  logic [VB+31:0]        rv_wide;
  logic [CW+6:0]         cnt_wide;
  sst_pkg::cell_ctl_t    ctl;

  // Chain wiring
  logic signed [VB-1:0]  entry [CAPACITY];
  logic                  gt    [CAPACITY];
  logic [0:0]            eq    [CAPACITY];
  logic [VB-1:0]         tap   [CAPACITY];
  logic [CAPACITY-1:0]   eq_vec;
  logic [0:0]            dup_root;
  logic [VB-1:0]         tap_root;

  // Take the input as a VALUE_BITS-bit number: truncate when narrower,
  // zero-extend the 32-bit pattern when wider.
  assign in_wide    = {{VB{1'b0}}, in_item.value};
  assign in_val     = in_wide[VB-1:0];
  assign in_pos_ext = PW'(in_item.position);
  assign count_ext  = PW'(count_r);

  // Hold ready low while in reset so no item is taken and then lost.
  assign in_item.ready = rst_n && (state_r == S_IDLE);
  assign fire_in       = in_item.valid && in_item.ready;

  // Cells compare against the incoming value while idle and insert the held
  // value at commit.
  assign bcast_value = (state_r == S_IDLE) ? in_val : value_r;

  assign dup    = dup_root[0];
  assign full   = (count_r == CAP_C);
  assign pos_ok = pos_r < count_ext;

  // Commit once the trees have settled and the output register is free.
  assign commit = (state_r == S_SUM) && (cnt_r == LV_C) &&
                  (!out_valid_r || out_item.ready);

  always_comb begin
    ctl.sample = fire_in;
    ctl.look   = (in_item.opcode == sst_pkg::OP_DELETE) ||
                 (in_item.opcode == sst_pkg::OP_READ);
    ctl.ins    = commit && (op_r == sst_pkg::OP_INSERT) && !dup && !full;
    ctl.del    = commit && (op_r == sst_pkg::OP_DELETE) && pos_ok;
  end

  // Decide the outcome of the held item.
  always_comb begin
    status_nxt = sst_pkg::ST_ABSENT;
    count_nxt  = count_r;
    case (op_r)
      sst_pkg::OP_INSERT: begin
        if (dup) begin
          status_nxt = sst_pkg::ST_DUPLICATE;
        end else if (full) begin
          status_nxt = sst_pkg::ST_FULL;
        end else begin
          status_nxt = sst_pkg::ST_INSERTED;
          count_nxt  = count_r + 1'b1;
        end
      end
      sst_pkg::OP_DELETE: begin
        if (pos_ok) begin
          status_nxt = sst_pkg::ST_DELETED;
          count_nxt  = count_r - 1'b1;
        end
      end
      sst_pkg::OP_READ: begin
        if (pos_ok) begin
          status_nxt = sst_pkg::ST_READ;
        end
      end
      default: begin
        status_nxt = sst_pkg::ST_ABSENT;
      end
    endcase
  end

  // The tap is zero unless a read or delete hit a valid entry, so the tree
  // root already carries zero for every other outcome.
  assign rv_wide  = {{32{tap_root[VB-1]}}, tap_root};
  assign cnt_wide = {7'b0, count_nxt};

  // Sequencer state and the result register: load the result at commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (fire_in) begin
            state_r <= S_SUM;
            cnt_r   <= '0;
          end
        end
        S_SUM: begin
          if (commit) begin
            state_r <= S_IDLE;
          end else if (cnt_r != LV_C) begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      if (commit) begin
        count_r       <= count_nxt;
        out_valid_r   <= 1'b1;
        status_r      <= status_nxt;
        read_value_r  <= rv_wide[31:0];
        entry_count_r <= cnt_wide[6:0];
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers: hold the item while it is processed.
  always_ff @(posedge clk) begin
    if (fire_in) begin
      op_r    <= sst_pkg::op_t'(in_item.opcode);
      pos_r   <= in_pos_ext;
      value_r <= in_val;
    end
  end

  assign out_item.valid       = out_valid_r;
  assign out_item.status      = status_r;
  assign out_item.read_value  = read_value_r;
  assign out_item.entry_count = entry_count_r;

  // Row of cells: each passes its entry and its "moves up" flag to the cell
  // above, and its entry to the cell below.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [VB-1:0] prev_entry;
    logic                 prev_gt;
    logic signed [VB-1:0] next_entry;

    if (i == 0) begin : g_first
      assign prev_entry = entry[0];
      assign prev_gt    = 1'b0;
    end else begin : g_mid
      assign prev_entry = entry[i-1];
      assign prev_gt    = gt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_entry = entry[i];
    end else begin : g_up
      assign next_entry = entry[i+1];
    end

    sst_cell #(
      .VB  (VB),
      .PW  (PW),
      .IDX (i)
    ) u_cell (
      .clk          (clk),
      .ctl_i        (ctl),
      .value_i      (bcast_value),
      .count_i      (count_ext),
      .pos_i        (in_pos_ext),
      .prev_entry_i (prev_entry),
      .prev_gt_i    (prev_gt),
      .next_entry_i (next_entry),
      .entry_o      (entry[i]),
      .gt_o         (gt[i]),
      .eq_o         (eq[i]),
      .tap_o        (tap[i])
    );

    assign eq_vec[i] = eq[i][0];
  end

  // Gather the duplicate flag and the read tap.
  sst_or_tree #(
    .WIDTH  (1),
    .LEAVES (CAPACITY)
  ) u_dup_tree (
    .clk    (clk),
    .leaf_i (eq),
    .root_o (dup_root)
  );

  sst_or_tree #(
    .WIDTH  (VB),
    .LEAVES (CAPACITY)
  ) u_tap_tree (
    .clk    (clk),
    .leaf_i (tap),
    .root_o (tap_root)
  );

  // The table never holds more than CAPACITY entries.
  `SST_ASSERT_IMPLY(a_count_max, 1'b1, count_r <= CAP_C)
  // An insert commits only with room left.
  `SST_ASSERT_IMPLY(a_ins_room, ctl.ins, count_r != CAP_C)
  // Sorted and duplicate-free: at most one cell matches the value.
  `SST_ASSERT_IMPLY(a_eq_onehot, state_r == S_SUM, $onehot0(eq_vec))
  // Every commit presents a result.
  `SST_ASSERT_NEXT(a_commit_out, commit, out_valid_r)

endmodule

@@ sim/sorted_set_table_unit_test.sv @@
`timescale 1ns / 1ps

module sorted_set_table_unit_test;

  localparam int CELLS          = 64;
  localparam int RESET_CYCLES   = 12;
  localparam int WATCHDOG_LIMIT = 2000;
  // Wait after draining, with a margin past the length of one table operation.
  localparam int SETTLE_CYCLES  = 16;
  localparam int REPORT_LIMIT   = 10;

  // The opcode field has one code that the block must ignore.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic signed [31:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;

  // What the table answers for one item.
  typedef struct {
    sst_pkg::status_t   status;
    logic signed [31:0] read_value;
    logic [6:0]         entry_count;
  } table_answer_t;

  logic clk = 1'b0;
  logic rst_n;

  sst_in_if  in_ch ();
  sst_out_if out_ch ();

  sorted_set_table_unit #(
    .CAPACITY   (CELLS),
    .VALUE_BITS (32)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_ch),
    .out_item (out_ch)
  );

  always #1 clk = ~clk;

  // Shadow copy of the table: ascending, unique, valid below shadow_count.
  logic signed [31:0] shadow_cells [0:CELLS-1];
  int                 shadow_count;

  // Answers still owed by the block, oldest first.
  table_answer_t pending_answers [$];

  int   error_count;
  int   idle_cycles;
  int   burst_left;
  bit   sender_idle_en;
  bit   stall_en;
  logic [5:0] stall_phase;
  logic [7:0] stall_mask;

  // Apply one item to the shadow table and return what the block must answer.
  function automatic table_answer_t predict_answer(input logic [1:0] op,
                                                   input logic signed [31:0] val,
                                                   input logic [5:0] pos);
    table_answer_t ans;
    int slot;
    int idx;
    ans.status     = sst_pkg::ST_ABSENT;
    ans.read_value = '0;
    idx            = int'(pos);
    case (op)
      sst_pkg::OP_INSERT: begin
        // Find the first entry not below the value.
        slot = 0;
        while (slot < shadow_count && shadow_cells[slot] < val) slot++;
        if (slot < shadow_count && shadow_cells[slot] == val) begin
          ans.status = sst_pkg::ST_DUPLICATE;
        end else if (shadow_count >= CELLS) begin
          ans.status = sst_pkg::ST_FULL;
        end else begin
          for (int k = shadow_count; k > slot; k--) shadow_cells[k] = shadow_cells[k-1];
          shadow_cells[slot] = val;
          shadow_count++;
          ans.status = sst_pkg::ST_INSERTED;
        end
      end
      sst_pkg::OP_DELETE: begin
        if (idx < shadow_count) begin
          ans.read_value = shadow_cells[idx];
          for (int k = idx; k + 1 < shadow_count; k++) shadow_cells[k] = shadow_cells[k+1];
          shadow_count--;
          ans.status = sst_pkg::ST_DELETED;
        end
      end
      sst_pkg::OP_READ: begin
        if (idx < shadow_count) begin
          ans.read_value = shadow_cells[idx];
          ans.status     = sst_pkg::ST_READ;
        end
      end
      default: begin
        // Unused opcode: table untouched, answered as an absent index.
      end
    endcase
    ans.entry_count = 7'(shadow_count);
    return ans;
  endfunction

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // Drive one item and hold it until the block takes it.
  task automatic send_item(input logic [1:0] op, input logic signed [31:0] val,
                           input logic [5:0] pos);
    in_ch.valid    <= 1'b1;
    in_ch.opcode   <= op;
    in_ch.value    <= val;
    in_ch.position <= pos;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    pending_answers.push_back(predict_answer(op, val, pos));
  endtask

  // Send one item; with sender idling enabled, drop valid for a random gap when the burst runs out.
  task automatic push_item(input logic [1:0] op, input logic signed [31:0] val,
                           input logic [5:0] pos);
    send_item(op, val, pos);
    if (sender_idle_en) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = $urandom_range(1, 24);
      end
    end
  endtask

  // Hold the sender until every owed answer has come back.
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Mostly indexes that hit a held entry, the rest anywhere in the field.
  function automatic logic [5:0] pick_position();
    if (shadow_count > 0 && $urandom_range(0, 99) < 80)
      return 6'($urandom_range(0, shadow_count - 1));
    return 6'($urandom_range(0, CELLS - 1));
  endfunction

  // Extremes, held entries (duplicates), a narrow band, or any 32-bit value.
  function automatic logic signed [31:0] pick_value(input int spread);
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return VAL_MAX;
    if (r == 1) return VAL_MIN;
    if (r < 6 && shadow_count > 0) return shadow_cells[$urandom_range(0, shadow_count - 1)];
    if (r < 12 && spread > 0) return 32'($urandom_range(0, 2 * spread)) - 32'(spread);
    return $urandom;
  endfunction

  // Empty the table through the block itself.
  task automatic clear_table();
    while (shadow_count > 0) push_item(sst_pkg::OP_DELETE, $urandom, '0);
  endtask

  task automatic test_directed_edges();
    // Empty table: reads and deletes anywhere find nothing.
    push_item(sst_pkg::OP_READ, '0, 6'd0);
    push_item(sst_pkg::OP_DELETE, '0, 6'd63);
    // Extremes and values around zero, out of order.
    push_item(sst_pkg::OP_INSERT, VAL_MAX, 6'd0);
    push_item(sst_pkg::OP_INSERT, VAL_MIN, 6'd63);
    push_item(sst_pkg::OP_INSERT, 32'sd0, 6'd0);
    push_item(sst_pkg::OP_INSERT, -32'sd1, 6'd0);
    push_item(sst_pkg::OP_INSERT, 32'sd1, 6'd0);
    // Duplicates leave the table unchanged.
    push_item(sst_pkg::OP_INSERT, VAL_MIN, 6'd0);
    push_item(sst_pkg::OP_INSERT, VAL_MAX, 6'd0);
    // Walk the table, then step past its end.
    for (int i = 0; i < 5; i++) push_item(sst_pkg::OP_READ, '0, 6'(i));
    push_item(sst_pkg::OP_READ, '0, 6'd5);
    push_item(sst_pkg::OP_READ, '0, 6'd63);
    push_item(OP_UNUSED, VAL_MAX, 6'd0);
    push_item(OP_UNUSED, '0, 6'd63);
    // Delete the top, the bottom, a middle entry, then past the end.
    push_item(sst_pkg::OP_DELETE, '0, 6'd4);
    push_item(sst_pkg::OP_DELETE, '0, 6'd0);
    push_item(sst_pkg::OP_DELETE, '0, 6'd1);
    push_item(sst_pkg::OP_DELETE, '0, 6'd2);
    push_item(sst_pkg::OP_READ, '0, 6'd0);
    push_item(sst_pkg::OP_READ, '0, 6'd1);
    wait_drained();
  endtask

  task automatic test_full_table();
    clear_table();
    while (shadow_count < CELLS) push_item(sst_pkg::OP_INSERT, $urandom, '0);
    // A new value is dropped; a held one is still reported as a duplicate.
    push_item(sst_pkg::OP_INSERT, $urandom, '0);
    push_item(sst_pkg::OP_INSERT, shadow_cells[10], '0);
    push_item(sst_pkg::OP_INSERT, shadow_cells[CELLS-1], '0);
    push_item(sst_pkg::OP_READ, '0, 6'd0);
    push_item(sst_pkg::OP_READ, '0, 6'd63);
    push_item(sst_pkg::OP_DELETE, '0, 6'd63);
    push_item(sst_pkg::OP_INSERT, VAL_MAX, '0);
    push_item(sst_pkg::OP_INSERT, VAL_MIN, '0);
    push_item(sst_pkg::OP_READ, '0, 6'd63);
    push_item(sst_pkg::OP_DELETE, '0, 6'd0);
    push_item(sst_pkg::OP_INSERT, VAL_MIN, '0);
    push_item(sst_pkg::OP_INSERT, VAL_MIN + 32'sd1, '0);
    push_item(sst_pkg::OP_DELETE, '0, 6'd63);
    wait_drained();
  endtask

  // Random operations; the insert share steers the table toward full or empty.
  task automatic run_random_mix(input int n_items, input int ins_pct, input int del_pct,
                                input int spread);
    int r;
    logic [1:0] op;
    for (int i = 0; i < n_items; i++) begin
      r = $urandom_range(0, 99);
      if (r < 2)                      op = OP_UNUSED;
      else if (r < ins_pct)           op = sst_pkg::OP_INSERT;
      else if (r < ins_pct + del_pct) op = sst_pkg::OP_DELETE;
      else                            op = sst_pkg::OP_READ;
      push_item(op, (op == sst_pkg::OP_INSERT) ? pick_value(spread) : $urandom,
                pick_position());
    end
  endtask

  task automatic test_random_fill();
    sender_idle_en = 1'b1;
    stall_en       = 1'b1;
    run_random_mix(300, 60, 20, 100);
    wait_drained();
  endtask

  task automatic test_random_churn();
    run_random_mix(300, 35, 45, 0);
    wait_drained();
  endtask

  task automatic test_back_to_back();
    // No idling on either side: every handshake as fast as the block allows.
    sender_idle_en = 1'b0;
    stall_en       = 1'b0;
    run_random_mix(250, 50, 30, 40);
    wait_drained();
  endtask

  task automatic test_narrow_band();
    // A narrow value band: heavy duplicate traffic near a full table.
    sender_idle_en = 1'b1;
    stall_en       = 1'b1;
    run_random_mix(200, 70, 15, 40);
    wait_drained();
  endtask

  // Receiver stalls on an 8-bit mask that is redrawn each time the 6-bit phase counter wraps.
  always @(posedge clk) begin
    stall_phase <= stall_phase + 6'd1;
    if (stall_phase == '0) begin
      stall_mask <= ($urandom_range(0, 3) == 0) ? 8'hFF : (8'($urandom) | 8'h01);
    end
    out_ch.ready <= !stall_en || stall_mask[stall_phase[2:0]];
  end

  // Match each result to the oldest owed answer.
  always @(posedge clk) begin
    table_answer_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_answers.size() == 0) begin
        flag_error($sformatf("unexpected result: status %0d value %0d count %0d",
                             out_ch.status, out_ch.read_value, out_ch.entry_count));
      end else begin
        want = pending_answers.pop_front();
        if (out_ch.status !== want.status || out_ch.read_value !== want.read_value ||
            out_ch.entry_count !== want.entry_count) begin
          flag_error($sformatf(
            "mismatch: expected status %0d value %0d count %0d, got %0d %0d %0d",
            want.status, want.read_value, want.entry_count,
            out_ch.status, out_ch.read_value, out_ch.entry_count));
        end
      end
    end
  end

  // End the run when neither channel moves an item for too long.
  always @(posedge clk) begin
    if (rst_n === 1'b1) begin
      if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
          (out_ch.valid === 1'b1 && out_ch.ready === 1'b1)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    error_count    = 0;
    idle_cycles    = 0;
    shadow_count   = 0;
    burst_left     = 1;
    sender_idle_en = 1'b1;
    stall_en       = 1'b1;
    stall_phase    = '0;
    stall_mask     = 8'hFF;
    out_ch.ready   = 1'b0;
    in_ch.valid    <= 1'b0;
    in_ch.opcode   <= sst_pkg::OP_INSERT;
    in_ch.value    <= '0;
    in_ch.position <= '0;
    rst_n          <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_edges();
    test_full_table();
    test_random_fill();
    test_random_churn();
    test_back_to_back();
    test_narrow_band();

    // Drain, then watch a little longer for stray results.
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    error_count += pending_answers.size();
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
